@@ design/dpc_pkg.sv @@
// ----------------------------------------------------------------------------
// dpc_pkg: shared types and constants for the determinant pair comparator
// Field widths, queue depth and the record passed from front to back.
// ----------------------------------------------------------------------------
package dpc_pkg;

  localparam int MaskW  = 32;  // occupation mask width
  localparam int CountW = 6;   // popcount width, 0..32
  localparam int OrbW   = 5;   // orbital index width
  localparam int SpinW  = 11;  // signed spin value width
  localparam int SumW   = CountW + 1;

  localparam logic [CountW-1:0] ActiveReset = 6'd32;
  localparam logic [SumW-1:0]   NzLimit     = 7'd4;
  localparam logic [CountW-1:0] FlipDiff    = 6'd2;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCountW    = $clog2(QueueDepth + 1);

  // classified item: masked occupations and their counts
  typedef struct packed {
    logic [MaskW-1:0]  a1;
    logic [MaskW-1:0]  b1;
    logic [MaskW-1:0]  a2;
    logic [MaskW-1:0]  b2;
    logic [CountW-1:0] na;
    logic [CountW-1:0] nb;
    logic [CountW-1:0] nab;
    logic [CountW-1:0] na2;
    logic [CountW-1:0] ad;
    logic [CountW-1:0] bd;
  } front_item_t;

endpackage

@@ design/dpc_front.sv @@
// ----------------------------------------------------------------------------
// dpc_front: masking and population counts
// Reduces the four masks to the active orbitals and counts occupations
// and differences for the back end.
// ----------------------------------------------------------------------------
module dpc_front #(
  parameter int MAX_ORBITALS = 32
) (
  input  logic [dpc_pkg::CountW-1:0] active_count_i,
  input  logic [dpc_pkg::MaskW-1:0]  first_alpha_i,
  input  logic [dpc_pkg::MaskW-1:0]  first_beta_i,
  input  logic [dpc_pkg::MaskW-1:0]  second_alpha_i,
  input  logic [dpc_pkg::MaskW-1:0]  second_beta_i,
  output dpc_pkg::front_item_t       item_o
);
  import dpc_pkg::*;

  localparam int EffMax = (MAX_ORBITALS < MaskW) ? MAX_ORBITALS : MaskW;

  function automatic logic [CountW-1:0] popcnt(input logic [MaskW-1:0] v);
    logic [CountW-1:0] c;
    c = '0;
    for (int k = 0; k < MaskW; k++) begin
      c = c + CountW'(v[k]);
    end
    return c;
  endfunction

  logic [CountW-1:0] eff_n;
  logic [MaskW-1:0]  mask;
  logic [MaskW-1:0]  a1, b1, a2, b2;

  always_comb begin
    eff_n = (active_count_i > CountW'(EffMax)) ? CountW'(EffMax) : active_count_i;
    if (eff_n >= CountW'(MaskW)) begin
      mask = '1;
    end else begin
      mask = (MaskW'(1) << eff_n) - MaskW'(1);
    end
  end

  assign a1 = first_alpha_i  & mask;
  assign b1 = first_beta_i   & mask;
  assign a2 = second_alpha_i & mask;
  assign b2 = second_beta_i  & mask;

  assign item_o.a1  = a1;
  assign item_o.b1  = b1;
  assign item_o.a2  = a2;
  assign item_o.b2  = b2;
  assign item_o.na  = popcnt(a1);
  assign item_o.nb  = popcnt(b1);
  assign item_o.nab = popcnt(a1 & b1);
  assign item_o.na2 = popcnt(a2);
  assign item_o.ad  = popcnt(a1 ^ a2);
  assign item_o.bd  = popcnt(b1 ^ b2);

endmodule

@@ design/dpc_queue.sv @@
// ----------------------------------------------------------------------------
// dpc_queue: short FIFO between front and back
// Register-based queue so either side can stall independently.
// ----------------------------------------------------------------------------
module dpc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dpc_pkg::front_item_t push_item_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 head_valid_o,
  output dpc_pkg::front_item_t head_item_o
);
  import dpc_pkg::*;

  front_item_t        mem_q [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCountW-1:0] count_q, count_d;

  assign full_o       = (count_q == QCountW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCountW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCountW'(QueueDepth))
    else $error("queue count beyond depth");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_o |-> !pop_i)
    else $error("pop from empty queue");

  a_count_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + QCountW'(1)))
    else $error("queue count lost a push");

endmodule

@@ design/dpc_back.sv @@
// ----------------------------------------------------------------------------
// dpc_back: spin value, flags and spin-flip decode
// Takes the queue head, finds differing orbitals, computes parity and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module dpc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_valid_i,
  input  dpc_pkg::front_item_t        head_item_i,
  output logic                        pop_o,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [dpc_pkg::CountW-1:0]  alpha_total_o,
  output logic signed [dpc_pkg::SpinW-1:0] spin_value_o,
  output logic [dpc_pkg::CountW-1:0]  alpha_diff_o,
  output logic [dpc_pkg::CountW-1:0]  beta_diff_o,
  output logic                        matrix_nonzero_o,
  output logic                        spin_flip_pair_o,
  output logic                        pair_parity_o,
  output logic [dpc_pkg::OrbW-1:0]    lower_orbital_o,
  output logic [dpc_pkg::OrbW-1:0]    upper_orbital_o
);
  import dpc_pkg::*;

  // lowest set bit; all-zero gives the top index
  function automatic logic [OrbW-1:0] low_bit(input logic [MaskW-1:0] v);
    logic [OrbW-1:0] k;
    k = OrbW'(MaskW - 1);
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (v[i]) begin
        k = OrbW'(i);
      end
    end
    return k;
  endfunction

  front_item_t       it;
  logic [MaskW-1:0]  da, db;
  logic [OrbW-1:0]   pa, qa, rb, sb;
  logic [CountW-1:0] absd;
  logic [SpinW-1:0]  sq;
  logic [SpinW-1:0]  spin;
  logic              nz, flip, par;
  logic [MaskW-1:0]  upto_p, upto_q;

  logic              out_valid_q;
  logic [CountW-1:0] alpha_total_q, alpha_diff_q, beta_diff_q;
  logic [SpinW-1:0]  spin_q;
  logic              nz_q, flip_q, par_q;
  logic [OrbW-1:0]   lower_q, upper_q;

  assign it = head_item_i;
  assign da = it.a1 ^ it.a2;
  assign db = it.b1 ^ it.b2;
  assign pa = low_bit(da);
  assign qa = low_bit(da & (da - MaskW'(1)));
  assign rb = low_bit(db);
  assign sb = low_bit(db & (db - MaskW'(1)));

  // bits 0..p and 0..q inclusive
  assign upto_p = MaskW'(({1'b0, {MaskW{1'b0}}} | (MaskW + 1)'(2)) << pa) - MaskW'(1);
  assign upto_q = MaskW'(({1'b0, {MaskW{1'b0}}} | (MaskW + 1)'(2)) << qa) - MaskW'(1);

  always_comb begin
    absd = (it.na >= it.nb) ? (it.na - it.nb) : (it.nb - it.na);
    sq   = SpinW'(absd) * SpinW'(absd);
    spin = {3'b000, it.nab, 2'b00} - sq;
    nz   = (it.na == it.na2) &&
           ((SumW'(it.ad) + SumW'(it.bd)) <= NzLimit);
    flip = (it.na == it.na2) && (it.ad == FlipDiff) && (it.bd == FlipDiff) &&
           (pa == rb) && (qa == sb) && ((it.a1[pa] ^ it.b1[pa]) == 1'b1);
    // popcount parity via xor-reduce; odd sign when the count sum is even
    par  = ~(^(it.a1 & ~upto_p) ^ ^(it.a2 & ~upto_q) ^
             ^(it.b1 & upto_q) ^ ^(it.b2 & upto_p));
  end

  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      alpha_total_q <= it.na;
      spin_q        <= spin;
      alpha_diff_q  <= it.ad;
      beta_diff_q   <= it.bd;
      nz_q          <= nz;
      flip_q        <= flip;
      par_q         <= flip & par;
      lower_q       <= flip ? pa : '0;
      upper_q       <= flip ? qa : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign alpha_total_o    = alpha_total_q;
  assign spin_value_o     = $signed(spin_q);
  assign alpha_diff_o     = alpha_diff_q;
  assign beta_diff_o      = beta_diff_q;
  assign matrix_nonzero_o = nz_q;
  assign spin_flip_pair_o = flip_q;
  assign pair_parity_o    = par_q;
  assign lower_orbital_o  = lower_q;
  assign upper_orbital_o  = upper_q;

  a_flip_needs_nz : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && spin_flip_pair_o) |-> matrix_nonzero_o)
    else $error("spin-flip pair without nonzero flag");

  a_flip_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && spin_flip_pair_o) |-> (lower_orbital_o < upper_orbital_o))
    else $error("spin-flip orbitals out of order");

  a_no_flip_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !spin_flip_pair_o) |->
      (!pair_parity_o && lower_orbital_o == '0 && upper_orbital_o == '0))
    else $error("pair fields set without spin-flip pair");

endmodule

@@ design/determinant_pair_compare.sv @@
// ----------------------------------------------------------------------------
// determinant_pair_compare: determinant pair excitation comparator
// Flow: the queue entry is written at the accepting edge, the output register
//   when the back end pops it, which waits while the output is stalled.
// Throughput: one transaction per cycle; input stalls only when the two-entry
//   queue is full, and the queue and output register stall independently.
// Reset: asynchronous active low; queue and output empty, active_count = 32.
// ----------------------------------------------------------------------------
module determinant_pair_compare #(
  parameter int MAX_ORBITALS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dpc_pkg::CountW-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [dpc_pkg::MaskW-1:0]        first_alpha_i,
  input  logic [dpc_pkg::MaskW-1:0]        first_beta_i,
  input  logic [dpc_pkg::MaskW-1:0]        second_alpha_i,
  input  logic [dpc_pkg::MaskW-1:0]        second_beta_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [dpc_pkg::CountW-1:0]       alpha_total_o,
  output logic signed [dpc_pkg::SpinW-1:0] spin_value_o,
  output logic [dpc_pkg::CountW-1:0]       alpha_diff_o,
  output logic [dpc_pkg::CountW-1:0]       beta_diff_o,
  output logic                             matrix_nonzero_o,
  output logic                             spin_flip_pair_o,
  output logic                             pair_parity_o,
  output logic [dpc_pkg::OrbW-1:0]         lower_orbital_o,
  output logic [dpc_pkg::OrbW-1:0]         upper_orbital_o
);
  import dpc_pkg::*;

  logic [CountW-1:0] active_q;
  front_item_t       front_item, head_item;
  logic              q_full, q_push, q_pop, head_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActiveReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_q <= cfg_data_i;
    end
  end

  dpc_front #(
    .MAX_ORBITALS(MAX_ORBITALS)
  ) u_front (
    .active_count_i(active_q),
    .first_alpha_i (first_alpha_i),
    .first_beta_i  (first_beta_i),
    .second_alpha_i(second_alpha_i),
    .second_beta_i (second_beta_i),
    .item_o        (front_item)
  );

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !in_stall_o;

  dpc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (front_item),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .head_valid_o(head_valid),
    .head_item_o (head_item)
  );

  dpc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_item_i     (head_item),
    .pop_o           (q_pop),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .alpha_total_o   (alpha_total_o),
    .spin_value_o    (spin_value_o),
    .alpha_diff_o    (alpha_diff_o),
    .beta_diff_o     (beta_diff_o),
    .matrix_nonzero_o(matrix_nonzero_o),
    .spin_flip_pair_o(spin_flip_pair_o),
    .pair_parity_o   (pair_parity_o),
    .lower_orbital_o (lower_orbital_o),
    .upper_orbital_o (upper_orbital_o)
  );

endmodule
